/* rtl/core/hsl2rgb_pkg.sv */
// ----------------------------------------------------------------------------
// HSL to RGB package
// Pixel types, fixed-point constants and the hue ramp used by the converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hsl2rgb_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned LevelW   = 2 * FracBits + 1;

  localparam logic [FracBits:0]   OneFx   = {1'b1, {FracBits{1'b0}}};
  localparam logic [FracBits-1:0] ThirdFx = FracBits'((1 << FracBits) / 3);
  localparam logic [FracBits-1:0] TwoThirdFx = FracBits'((1 << FracBits) - ThirdFx);
  localparam logic [LevelW-1:0]   OneSqFx = {1'b1, {(2 * FracBits){1'b0}}};

  typedef struct packed {
    logic [FracBits-1:0] hue;
    logic [FracBits:0]   saturation;
    logic [FracBits:0]   lightness;
  } hsl_pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_pixel_t;

  // Piecewise-linear weight of one channel at hue position t, from 0 to one.
  function automatic logic [FracBits:0] ramp_weight(logic [FracBits-1:0] t);
    logic [FracBits+2:0] six_t;
    logic [FracBits+2:0] three_t;
    logic [FracBits+2:0] fall;
    logic [FracBits:0]   w;
    six_t   = ({3'b000, t} << 2) + ({3'b000, t} << 1);
    three_t = ({3'b000, t} << 1) + {3'b000, t};
    fall    = ({2'b00, OneFx} << 2) - six_t;
    if (six_t < {2'b00, OneFx}) begin
      w = six_t[FracBits:0];
    end else if (!t[FracBits-1]) begin
      w = OneFx;
    end else if (three_t < ({2'b00, OneFx} << 1)) begin
      w = fall[FracBits:0];
    end else begin
      w = '0;
    end
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/hsl_to_rgb_converter_core.sv */
// ----------------------------------------------------------------------------
// HSL to RGB converter core
// An accepted input beat is registered in stages 1, 2 and 3 and then in the output register.
// Throughput is one pixel per cycle; the four-stage pipeline stalls in place.
// Reset clears all stage valid bits; no pixel data is reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hsl_to_rgb_converter_core
  import hsl2rgb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire hsl_pixel_t in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output rgb_pixel_t      out_data_o
);

  localparam int unsigned F = FracBits;

  logic en1, en2, en3, en4;
  logic v1_q, v2_q, v3_q, v4_q;

  // Stage 1: clamp, lightness distance to the nearer end, channel hue offsets.
  logic [F:0]   s_clamp, l_clamp, l_comp;
  logic [F:0]   s1_s_q, s1_l_q;
  logic [F-1:0] s1_m_q, s1_tr_q, s1_tg_q, s1_tb_q;
  logic [F:0]   m_d;
  logic [F:0]   tr_sum, tb_sum;

  // Stage 2: half chroma and ramp weights.
  logic [2*F:0] sm_prod;
  logic [F-1:0] s2_c_q;
  logic [F:0]   s2_l_q, s2_rr_q, s2_rg_q, s2_rb_q;

  // Stage 3: channel levels.
  logic [LevelW-1:0] base_d;
  logic [2*F:0]      pr_d, pg_d, pb_d;
  logic [LevelW:0]   vr_d, vg_d, vb_d;
  logic [LevelW-1:0] s3_vr_q, s3_vg_q, s3_vb_q;

  rgb_pixel_t out_q;

  assign en4        = !v4_q || out_ready_i;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_comb begin
    s_clamp = (in_data_i.saturation > OneFx) ? OneFx : in_data_i.saturation;
    l_clamp = (in_data_i.lightness > OneFx) ? OneFx : in_data_i.lightness;
    l_comp  = OneFx - l_clamp;
    m_d     = (l_clamp < l_comp) ? l_clamp : l_comp;
    tr_sum  = {1'b0, in_data_i.hue} + {1'b0, ThirdFx};
    tb_sum  = {1'b0, in_data_i.hue} + {1'b0, TwoThirdFx};
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && en1) begin
      s1_s_q  <= s_clamp;
      s1_l_q  <= l_clamp;
      s1_m_q  <= m_d[F-1:0];
      s1_tr_q <= tr_sum[F-1:0];
      s1_tg_q <= in_data_i.hue;
      s1_tb_q <= tb_sum[F-1:0];
    end
  end

  assign sm_prod = {{F{1'b0}}, s1_s_q} * {{(F+1){1'b0}}, s1_m_q};

  always_ff @(posedge clk_i) begin
    if (v1_q && en2) begin
      s2_c_q  <= sm_prod[2*F-1:F];
      s2_l_q  <= s1_l_q;
      s2_rr_q <= ramp_weight(s1_tr_q);
      s2_rg_q <= ramp_weight(s1_tg_q);
      s2_rb_q <= ramp_weight(s1_tb_q);
    end
  end

  always_comb begin
    base_d = {(s2_l_q - {1'b0, s2_c_q}), {F{1'b0}}};
    pr_d   = {{(F+1){1'b0}}, s2_c_q} * {{F{1'b0}}, s2_rr_q};
    pg_d   = {{(F+1){1'b0}}, s2_c_q} * {{F{1'b0}}, s2_rg_q};
    pb_d   = {{(F+1){1'b0}}, s2_c_q} * {{F{1'b0}}, s2_rb_q};
    vr_d   = {1'b0, base_d} + {pr_d, 1'b0};
    vg_d   = {1'b0, base_d} + {pg_d, 1'b0};
    vb_d   = {1'b0, base_d} + {pb_d, 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && en3) begin
      s3_vr_q <= vr_d[LevelW-1:0];
      s3_vg_q <= vg_d[LevelW-1:0];
      s3_vb_q <= vb_d[LevelW-1:0];
    end
  end

  function automatic logic [7:0] to_channel(logic [LevelW-1:0] v);
    logic [LevelW+7:0] scaled;
    logic [8:0]        ch;
    scaled = ({8'd0, v} << 8) - {8'd0, v};
    ch     = scaled[2*F+8:2*F];
    return ch[8] ? 8'hFF : ch[7:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (v3_q && en4) begin
      out_q.red   <= to_channel(s3_vr_q);
      out_q.green <= to_channel(s3_vg_q);
      out_q.blue  <= to_channel(s3_vb_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_in_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v1_q)
    else $error("accepted input beat did not enter the first stage");

  a_out_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && en4 |=> v4_q)
    else $error("pixel lost between the last stage and the output register");

  a_level_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (s3_vr_q <= OneSqFx) && (s3_vg_q <= OneSqFx) && (s3_vb_q <= OneSqFx))
    else $error("channel level exceeds full scale");
`endif

endmodule

`default_nettype wire

/* tb/sv/hsl_to_rgb_converter_core_tb.sv */
// ----------------------------------------------------------------------------
// HSL to RGB converter core testbench
// Drives directed corner pixels and then random pixels through the converter
// with bursty input traffic and a stalling output, predicts each RGB beat in
// fixed point and compares every field in order of arrival.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class rgb_scoreboard;
  hsl2rgb_pkg::rgb_pixel_t expected_q[$];
  int unsigned errors;
  int unsigned checked;

  function new();
    errors  = 0;
    checked = 0;
  endfunction

  static function logic [7:0] channel_value(longint unsigned l, longint unsigned c,
                                            longint unsigned t);
    longint unsigned one_v;
    longint unsigned w;
    longint unsigned v;
    longint unsigned ch;
    one_v = 64'd1 << hsl2rgb_pkg::FracBits;
    t = t & (one_v - 1);
    if (6 * t < one_v) begin
      w = 6 * t;
    end else if (2 * t < one_v) begin
      w = one_v;
    end else if (3 * t < 2 * one_v) begin
      w = 4 * one_v - 6 * t;
    end else begin
      w = 0;
    end
    v  = (l - c) * one_v + 2 * c * w;
    ch = (v * 255) >> (2 * hsl2rgb_pkg::FracBits);
    if (ch > 255) begin
      ch = 255;
    end
    return ch[7:0];
  endfunction

  static function hsl2rgb_pkg::rgb_pixel_t predict_rgb(hsl2rgb_pkg::hsl_pixel_t px);
    longint unsigned one_v;
    longint unsigned third_v;
    longint unsigned h;
    longint unsigned s;
    longint unsigned l;
    longint unsigned m;
    longint unsigned c;
    hsl2rgb_pkg::rgb_pixel_t rgb;
    one_v   = 64'd1 << hsl2rgb_pkg::FracBits;
    third_v = one_v / 3;
    h = 64'(px.hue);
    s = 64'(px.saturation);
    l = 64'(px.lightness);
    if (s > one_v) begin
      s = one_v;
    end
    if (l > one_v) begin
      l = one_v;
    end
    m = (l < one_v - l) ? l : one_v - l;
    c = (s * m) >> hsl2rgb_pkg::FracBits;
    rgb.red   = channel_value(l, c, h + third_v);
    rgb.green = channel_value(l, c, h);
    rgb.blue  = channel_value(l, c, h + one_v - third_v);
    return rgb;
  endfunction

  function void note_input(hsl2rgb_pkg::hsl_pixel_t px);
    expected_q.push_back(predict_rgb(px));
  endfunction

  function void check_output(hsl2rgb_pkg::rgb_pixel_t got);
    hsl2rgb_pkg::rgb_pixel_t exp_px;
    if (expected_q.size() == 0) begin
      $error("output beat with no pixel pending: %h", got);
      errors++;
      return;
    end
    exp_px = expected_q.pop_front();
    checked++;
    if (got.red !== exp_px.red) begin
      $error("red: expected %0d, actual %0d", exp_px.red, got.red);
      errors++;
    end
    if (got.green !== exp_px.green) begin
      $error("green: expected %0d, actual %0d", exp_px.green, got.green);
      errors++;
    end
    if (got.blue !== exp_px.blue) begin
      $error("blue: expected %0d, actual %0d", exp_px.blue, got.blue);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction
endclass

module hsl_to_rgb_converter_core_tb;
  import hsl2rgb_pkg::*;

  localparam int unsigned NumRandom  = 500;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned OneV       = 1 << FracBits;
  localparam int unsigned MaxSl      = (1 << (FracBits + 1)) - 1;
  localparam int unsigned MaxHue     = (1 << FracBits) - 1;
  localparam int unsigned Third      = OneV / 3;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  hsl_pixel_t in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  rgb_pixel_t out_data;

  rgb_scoreboard sb = new();
  int unsigned   cycles = 0;

  hsl_to_rgb_converter_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[hsl_to_rgb_converter_core] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_output(out_data);
    end
  end

  task automatic send_pixel(int unsigned h, int unsigned s, int unsigned l);
    hsl_pixel_t px;
    px.hue        = h[FracBits-1:0];
    px.saturation = s[FracBits:0];
    px.lightness  = l[FracBits:0];
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= px;
    do begin
      @(posedge clk);
    end while (!in_ready);
    sb.note_input(px);
  endtask

  task automatic idle_sender(int unsigned n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  function automatic int unsigned pick_level();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      return 0;
    end else if (r == 1) begin
      return OneV;
    end else if (r == 2) begin
      return OneV / 2;
    end else if (r < 5) begin
      return $urandom_range(OneV + 1, MaxSl);
    end
    return $urandom_range(0, OneV);
  endfunction

  // Receiver: segments of always-ready, random, periodic and blocked output,
  // with one long hold once traffic is flowing so that the pipeline backs up.
  initial begin
    int unsigned mode;
    int unsigned len;
    int unsigned k;
    bit          long_done;
    long_done = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!long_done && sb.checked >= 60) begin
        long_done = 1'b1;
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (LongHold - 1) @(negedge clk);
      end
      mode = $urandom_range(0, 3);
      len  = $urandom_range(4, 48);
      for (k = 0; k < len; k++) begin
        @(negedge clk);
        case (mode)
          0: begin
            out_ready <= 1'b1;
          end
          1: begin
            out_ready <= 1'($urandom_range(0, 1));
          end
          2: begin
            out_ready <= (k % 3) != 2;
          end
          default: begin
            out_ready <= 1'b0;
          end
        endcase
      end
    end
  end

  initial begin
    int unsigned n;
    int unsigned burst;
    int unsigned gap;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_pixel(0, OneV, OneV / 2);
    send_pixel(Third, OneV, OneV / 2);
    send_pixel(OneV - Third, OneV, OneV / 2);
    send_pixel(MaxHue, OneV, OneV / 2);
    send_pixel(OneV / 6, OneV, OneV / 2);
    send_pixel(OneV / 6 + 1, OneV, OneV / 2);
    send_pixel(OneV / 2 - 1, OneV, OneV / 2);
    send_pixel(OneV / 2, OneV, OneV / 2);
    send_pixel(OneV - Third + 1, OneV, OneV / 2);
    send_pixel(12345, 0, 0);
    send_pixel(12345, 0, OneV);
    send_pixel(12345, 0, 40000);
    send_pixel(5000, OneV, 0);
    send_pixel(5000, OneV, OneV);
    send_pixel(30000, MaxSl, OneV / 2);
    send_pixel(30000, 40000, MaxSl);
    send_pixel(60000, MaxSl, MaxSl);
    send_pixel(0, 0, 0);
    send_pixel(MaxHue, MaxSl, MaxSl);
    send_pixel(20000, OneV - 1, OneV - 1);
    send_pixel(20000, OneV - 1, 1);
    send_pixel(45000, OneV + 1, OneV + 1);
    idle_sender(3);

    n = 0;
    while (n < NumRandom) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && n < NumRandom) begin
        send_pixel($urandom_range(0, MaxHue), pick_level(), pick_level());
        burst--;
        n++;
      end
      gap = $urandom_range(0, 7);
      if (gap > 2) begin
        idle_sender(gap - 2);
      end
    end
    idle_sender(1);

    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[hsl_to_rgb_converter_core] OK");
    end else begin
      $display("[hsl_to_rgb_converter_core] ERROR");
    end
    $finish;
  end
endmodule
